/* rtl/lsws_pkg.sv */
// Shared types and constants of the LIFO stack with swap.
`default_nettype none
package lsws_pkg;

	localparam int unsigned DEPTH  = 64;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [DATA_W-1:0] data_t;

	typedef enum logic [2:0] {
		MODE_PUSH = 3'd0,
		MODE_DUMP = 3'd1,
		MODE_PEEK = 3'd2,
		MODE_POP  = 3'd3,
		MODE_SWAP = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_VALUE      = 3'd0,
		ST_PEEK_EMPTY = 3'd1,
		ST_POP_EMPTY  = 3'd2,
		ST_SWAP_SHORT = 3'd3,
		ST_PUSH_FULL  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_READ,
		FS_ERR,
		FS_SWAP_A,
		FS_SWAP_B,
		FS_SWAP_C
	} fsm_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		data_t wdata;
		logic  re;
		addr_t raddr;
	} ram_req_t;

	typedef struct packed {
		logic               ld;
		logic signed [31:0] value;
		status_t            status;
		logic               last;
	} out_ld_t;

endpackage
`default_nettype wire

/* rtl/lsws_cmd_if.sv */
// Command channel: operation mode and push value.
`default_nettype none
interface lsws_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [31:0] push_value;

	modport source (output valid, output mode, output push_value, input ready);
	modport sink (input valid, input mode, input push_value, output ready);
endinterface
`default_nettype wire

/* rtl/lsws_rsp_if.sv */
// Response channel: value, status and last flag.
`default_nettype none
interface lsws_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_value;
	logic [2:0]         status;
	logic               last;

	modport source (output valid, output out_value, output status, output last, input ready);
	modport sink (input valid, input out_value, input status, input last, output ready);
endinterface
`default_nettype wire

/* rtl/lifo_stack_with_swap_unit.sv */
// Top level of the LIFO stack with swap.
//
// cmd carries one word per operation: mode (push, dump, peek, pop, swap) and
// push_value. rsp carries result words: out_value, status and last.
// Entries live in one RAM with a registered read; a fill count
// register marks the top.
// Push and pop give no word. Peek reads the RAM, then loads the result
// register; swap makes two reads, then two writes through the single write
// port. A dump issues one RAM read per cycle and gives one word per cycle
// while the result register is free, top first, last set on the bottom entry.
// A failed operation gives one error word with value 0 and last set.
// cmd.ready is high while the sequencer is idle; a result word waiting in the
// output register does not block the next push or pop.
// When rsp.ready is low the result register holds its word and a dump pauses
// its reads until the register frees up.
// Reset empties the stack and clears all pending results; stored entries are
// not cleared since nothing below the fill count is read before it is written.
`default_nettype none
module lifo_stack_with_swap_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lsws_cmd_if.sink   cmd,
	lsws_rsp_if.source rsp
);

	lsws_pkg::ram_req_t req;
	lsws_pkg::data_t    rdata;
	lsws_pkg::out_ld_t  ld;
	logic               out_free;

	lsws_ram #(
		.WIDTH(lsws_pkg::DATA_W),
		.DEPTH(lsws_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (req.we),
		.waddr(req.waddr),
		.wdata(req.wdata),
		.re   (req.re),
		.raddr(req.raddr),
		.rdata(rdata)
	);

	lsws_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.req     (req),
		.rdata   (rdata),
		.ld      (ld),
		.out_free(out_free)
	);

	lsws_out u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.ld    (ld),
		.free  (out_free),
		.rsp   (rsp)
	);

endmodule
`default_nettype wire

/* rtl/lsws_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none
module lsws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// rdata holds while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/lsws_out.sv */
// Output register stage of the response channel.
`default_nettype none
module lsws_out (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lsws_pkg::out_ld_t ld,
	output logic                  free,
	lsws_rsp_if.source            rsp
);

	logic               v_q;
	logic signed [31:0] value_q;
	logic [2:0]         status_q;
	logic               last_q;

	assign free = !v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ld.ld) begin
			v_q <= 1'b1;
		end else if (rsp.ready) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.ld) begin
			value_q  <= ld.value;
			status_q <= ld.status;
			last_q   <= ld.last;
		end
	end

	assign rsp.valid     = v_q;
	assign rsp.out_value = value_q;
	assign rsp.status    = status_q;
	assign rsp.last      = last_q;

endmodule
`default_nettype wire

/* rtl/lsws_ctrl.sv */
// Stack sequencer: fill count, memory access and result generation.
`default_nettype none
module lsws_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	lsws_cmd_if.sink                cmd,
	output lsws_pkg::ram_req_t      req,
	input  wire lsws_pkg::data_t    rdata,
	output lsws_pkg::out_ld_t       ld,
	input  wire logic               out_free
);

	lsws_pkg::fsm_t    state_q, state_d;
	lsws_pkg::cnt_t    cnt_q, cnt_d;
	lsws_pkg::cnt_t    rem_q, rem_d;
	lsws_pkg::addr_t   ptr_q, ptr_d;
	logic              dv_q, dv_d;
	logic              dl_q, dl_d;
	lsws_pkg::data_t   tmp_q, tmp_d;
	lsws_pkg::status_t err_q, err_d;

	lsws_pkg::cnt_t  cnt_m1, cnt_m2;
	lsws_pkg::addr_t top_addr, sec_addr;
	logic            empty, full, consume;

	assign cnt_m1   = cnt_q - lsws_pkg::cnt_t'(1);
	assign cnt_m2   = cnt_q - lsws_pkg::cnt_t'(2);
	assign top_addr = cnt_m1[lsws_pkg::ADDR_W-1:0];
	assign sec_addr = cnt_m2[lsws_pkg::ADDR_W-1:0];
	assign empty    = cnt_q == '0;
	assign full     = cnt_q == lsws_pkg::cnt_t'(lsws_pkg::DEPTH);
	// read data is pending in the RAM output and the result register can take it
	assign consume  = dv_q && out_free;

	assign cmd.ready = state_q == lsws_pkg::FS_IDLE;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		rem_d   = rem_q;
		ptr_d   = ptr_q;
		dv_d    = dv_q;
		dl_d    = dl_q;
		tmp_d   = tmp_q;
		err_d   = err_q;
		req     = '0;
		ld      = '0;
		case (state_q)
			lsws_pkg::FS_IDLE: begin
				if (cmd.valid) begin
					case (lsws_pkg::mode_t'(cmd.mode))
						lsws_pkg::MODE_PUSH: begin
							if (full) begin
								err_d   = lsws_pkg::ST_PUSH_FULL;
								state_d = lsws_pkg::FS_ERR;
							end else begin
								req.we    = 1'b1;
								req.waddr = cnt_q[lsws_pkg::ADDR_W-1:0];
								req.wdata = cmd.push_value;
								cnt_d     = cnt_q + lsws_pkg::cnt_t'(1);
							end
						end
						lsws_pkg::MODE_DUMP: begin
							if (!empty) begin
								req.re    = 1'b1;
								req.raddr = top_addr;
								dv_d      = 1'b1;
								dl_d      = cnt_q == lsws_pkg::cnt_t'(1);
								ptr_d     = top_addr - lsws_pkg::addr_t'(1);
								rem_d     = cnt_m1;
								state_d   = lsws_pkg::FS_READ;
							end
						end
						lsws_pkg::MODE_PEEK: begin
							if (empty) begin
								err_d   = lsws_pkg::ST_PEEK_EMPTY;
								state_d = lsws_pkg::FS_ERR;
							end else begin
								req.re    = 1'b1;
								req.raddr = top_addr;
								dv_d      = 1'b1;
								dl_d      = 1'b1;
								rem_d     = '0;
								state_d   = lsws_pkg::FS_READ;
							end
						end
						lsws_pkg::MODE_POP: begin
							if (empty) begin
								err_d   = lsws_pkg::ST_POP_EMPTY;
								state_d = lsws_pkg::FS_ERR;
							end else begin
								cnt_d = cnt_m1;
							end
						end
						lsws_pkg::MODE_SWAP: begin
							if (cnt_q < lsws_pkg::cnt_t'(2)) begin
								err_d   = lsws_pkg::ST_SWAP_SHORT;
								state_d = lsws_pkg::FS_ERR;
							end else begin
								req.re    = 1'b1;
								req.raddr = top_addr;
								state_d   = lsws_pkg::FS_SWAP_A;
							end
						end
						default: begin
						end
					endcase
				end
			end
			lsws_pkg::FS_READ: begin
				ld.ld     = consume;
				ld.value  = rdata;
				ld.status = lsws_pkg::ST_VALUE;
				ld.last   = dl_q;
				if (rem_q != '0 && (!dv_q || consume)) begin
					req.re    = 1'b1;
					req.raddr = ptr_q;
					ptr_d     = ptr_q - lsws_pkg::addr_t'(1);
					rem_d     = rem_q - lsws_pkg::cnt_t'(1);
					dv_d      = 1'b1;
					dl_d      = rem_q == lsws_pkg::cnt_t'(1);
				end else if (consume) begin
					dv_d = 1'b0;
					if (rem_q == '0) begin
						state_d = lsws_pkg::FS_IDLE;
					end
				end else if (!dv_q) begin
					state_d = lsws_pkg::FS_IDLE;
				end
			end
			lsws_pkg::FS_ERR: begin
				ld.ld     = out_free;
				ld.value  = '0;
				ld.status = err_q;
				ld.last   = 1'b1;
				if (out_free) begin
					state_d = lsws_pkg::FS_IDLE;
				end
			end
			lsws_pkg::FS_SWAP_A: begin
				tmp_d     = rdata;
				req.re    = 1'b1;
				req.raddr = sec_addr;
				state_d   = lsws_pkg::FS_SWAP_B;
			end
			lsws_pkg::FS_SWAP_B: begin
				req.we    = 1'b1;
				req.waddr = top_addr;
				req.wdata = rdata;
				state_d   = lsws_pkg::FS_SWAP_C;
			end
			lsws_pkg::FS_SWAP_C: begin
				req.we    = 1'b1;
				req.waddr = sec_addr;
				req.wdata = tmp_q;
				state_d   = lsws_pkg::FS_IDLE;
			end
			default: begin
				state_d = lsws_pkg::FS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsws_pkg::FS_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			dv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
			dv_q    <= dv_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		dl_q  <= dl_d;
		tmp_q <= tmp_d;
		err_q <= err_d;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lsws_pkg::cnt_t'(lsws_pkg::DEPTH))
		else $error("fill count above depth");

	a_no_write_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |-> state_q != lsws_pkg::FS_READ)
		else $error("memory write during a read walk");

	a_pending_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		dv_q |-> state_q == lsws_pkg::FS_READ)
		else $error("read data pending outside a read walk");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ld.ld |-> out_free)
		else $error("result register overwritten");

	a_swap_keeps_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lsws_pkg::FS_SWAP_C |=> cnt_q == $past(cnt_q))
		else $error("swap changed the fill count");

endmodule
`default_nettype wire
